/* hw/rtl/tfds_pkg.sv */
// Package: shared widths, state and select codes, command and status structs.
`timescale 1ns / 1ps
package tfds_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV_BS,
    ST_DIV_PS,
    ST_FWD_START,
    ST_FWD,
    ST_BWD_START,
    ST_BWD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_BOUND_STEP,
    DIV_PREF_STEP,
    DIV_NB_D
  } div_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_PREF,
    RES_FALLBACK,
    RES_QSTEP,
    RES_DSTEP
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_nb;
    logic     save_np;
    logic     d_init;
    logic     d_inc;
    logic     d_dec;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pref_nonpos;
    logic dyn;
    logic bound_nonpos;
    logic pref_lt_step;
    logic div_done;
    logic rem_zero;
    logic d_gt_q;
    logic q_le_np;
    logic d_le_np;
    logic d_zero;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/tfds_if.sv */
// Interfaces: input query channel and tile factor result channel.
`timescale 1ns / 1ps
interface tfds_in_if;
  logic                                valid;
  logic                                ready;
  logic                                bound_is_dynamic;
  logic signed [tfds_pkg::VALUE_BITS-1:0] loop_bound;
  logic signed [tfds_pkg::VALUE_BITS-1:0] preferred_size;
  logic signed [tfds_pkg::VALUE_BITS-1:0] required_multiple;

  modport source (output valid, bound_is_dynamic, loop_bound, preferred_size,
                  required_multiple, input ready);
  modport sink (input valid, bound_is_dynamic, loop_bound, preferred_size,
                required_multiple, output ready);
  modport monitor (input valid, ready, bound_is_dynamic, loop_bound, preferred_size,
                   required_multiple);
endinterface

interface tfds_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfds_pkg::VALUE_BITS-1:0] tile_factor;

  modport source (output valid, tile_factor, input ready);
  modport sink (input valid, tile_factor, output ready);
  modport monitor (input valid, ready, tile_factor);
endinterface

/* hw/rtl/tfds_divider.sv */
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tfds_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tfds_pkg::VALUE_BITS-1:0] dividend,
  input  logic [tfds_pkg::VALUE_BITS-1:0] divisor,
  output logic                            done,
  output logic [tfds_pkg::VALUE_BITS-1:0] quotient,
  output logic [tfds_pkg::VALUE_BITS-1:0] remainder
);

  localparam int VB = tfds_pkg::VALUE_BITS;

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [tfds_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VB-1:0]                rem_r, rem_nxt;
  logic [VB-1:0]                quo_r, quo_nxt;
  logic [VB-1:0]                div_r, div_nxt;
  logic [VB:0]                  trial;
  logic                         ge;

  always_comb begin
    trial    = {rem_r, quo_r[VB-1]};
    ge       = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tfds_pkg::CNT_BITS'(VB);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract where it fits
      rem_nxt = ge ? VB'(trial - {1'b0, div_r}) : trial[VB-1:0];
      quo_nxt = {quo_r[VB-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tfds_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hw/rtl/tfds_datapath.sv */
// Datapath: operand registers, trial divisor, divider, result and output register.
`timescale 1ns / 1ps
module tfds_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfds_pkg::cmd_t       cmd,
  output tfds_pkg::sts_t       sts,
  tfds_in_if.sink              in_if,
  tfds_out_if.source           out_if
);

  localparam int VB = tfds_pkg::VALUE_BITS;

  logic                 dyn_r;
  logic signed [VB-1:0] bound_r, pref_r, step_r;
  logic [VB-1:0]        nb_r, np_r, d_r;
  logic signed [VB-1:0] res_r, out_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [VB-1:0]        div_a, div_b, quo, rem;
  logic                 div_done;
  logic signed [VB-1:0] fallback;
  logic [VB-1:0]        mul_a;
  logic signed [VB-1:0] res_nxt;

  tfds_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    case (cmd.div_sel)
      tfds_pkg::DIV_BOUND_STEP: begin
        div_a = bound_r;
        div_b = step_r;
      end
      tfds_pkg::DIV_PREF_STEP: begin
        div_a = pref_r;
        div_b = step_r;
      end
      tfds_pkg::DIV_NB_D: begin
        div_a = nb_r;
        div_b = d_r;
      end
      default: begin
        div_a = nb_r;
        div_b = d_r;
      end
    endcase
  end

  assign fallback = (bound_r < pref_r) ? bound_r : pref_r;
  assign mul_a    = (cmd.res_sel == tfds_pkg::RES_DSTEP) ? d_r : quo;

  always_comb begin
    case (cmd.res_sel)
      tfds_pkg::RES_ZERO:     res_nxt = '0;
      tfds_pkg::RES_PREF:     res_nxt = pref_r;
      tfds_pkg::RES_FALLBACK: res_nxt = fallback;
      tfds_pkg::RES_QSTEP,
      tfds_pkg::RES_DSTEP:    res_nxt = VB'(mul_a * step_r);
      default:                res_nxt = fallback;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready)
      out_valid_nxt = 1'b0;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dyn_r   <= in_if.bound_is_dynamic;
      bound_r <= in_if.loop_bound;
      pref_r  <= in_if.preferred_size;
      // clamp the multiple to at least one
      step_r  <= (in_if.required_multiple < VB'(signed'(1))) ? VB'(1)
                                                              : in_if.required_multiple;
    end
    if (cmd.save_nb)
      nb_r <= quo;
    if (cmd.save_np)
      np_r <= quo;
    if (cmd.d_init)
      d_r <= VB'(1);
    else if (cmd.d_inc)
      d_r <= d_r + 1'b1;
    else if (cmd.d_dec)
      d_r <= d_r - 1'b1;
    if (cmd.res_load)
      res_r <= res_nxt;
    if (cmd.out_load)
      out_data_r <= res_r;
  end

  always_comb begin
    sts.pref_nonpos  = (pref_r <= 0);
    sts.dyn          = dyn_r;
    sts.bound_nonpos = (bound_r <= 0);
    sts.pref_lt_step = (pref_r < step_r);
    sts.div_done     = div_done;
    sts.rem_zero     = (rem == '0);
    sts.d_gt_q       = (d_r > quo);
    sts.q_le_np      = (quo <= np_r);
    sts.d_le_np      = (d_r <= np_r);
    sts.d_zero       = (d_r == '0);
    sts.out_free     = !out_valid_r || out_if.ready;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.tile_factor = out_data_r;

endmodule

/* hw/rtl/tfds_ctrl.sv */
// Controller: sequences classification, step divisions and the divisor search.
`timescale 1ns / 1ps
module tfds_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tfds_pkg::sts_t  sts,
  output tfds_pkg::cmd_t  cmd
);

  tfds_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = tfds_pkg::DIV_NB_D;
    cmd.res_sel = tfds_pkg::RES_FALLBACK;
    in_ready  = 1'b0;
    case (state_r)
      tfds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tfds_pkg::ST_CLASSIFY;
        end
      end
      tfds_pkg::ST_CLASSIFY: begin
        if (sts.pref_nonpos) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tfds_pkg::RES_ZERO;
          state_nxt    = tfds_pkg::ST_EMIT;
        end else if (sts.dyn) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tfds_pkg::RES_PREF;
          state_nxt    = tfds_pkg::ST_EMIT;
        end else if (sts.bound_nonpos || sts.pref_lt_step) begin
          cmd.res_load = 1'b1;
          state_nxt    = tfds_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tfds_pkg::DIV_BOUND_STEP;
          state_nxt     = tfds_pkg::ST_DIV_BS;
        end
      end
      tfds_pkg::ST_DIV_BS: begin
        if (sts.div_done) begin
          if (!sts.rem_zero) begin
            cmd.res_load = 1'b1;
            state_nxt    = tfds_pkg::ST_EMIT;
          end else begin
            cmd.save_nb   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = tfds_pkg::DIV_PREF_STEP;
            state_nxt     = tfds_pkg::ST_DIV_PS;
          end
        end
      end
      tfds_pkg::ST_DIV_PS: begin
        if (sts.div_done) begin
          cmd.save_np = 1'b1;
          cmd.d_init  = 1'b1;
          state_nxt   = tfds_pkg::ST_FWD_START;
        end
      end
      tfds_pkg::ST_FWD_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = tfds_pkg::ST_FWD;
      end
      tfds_pkg::ST_FWD: begin
        if (sts.div_done) begin
          if (sts.d_gt_q) begin
            cmd.d_dec = 1'b1;
            state_nxt = tfds_pkg::ST_BWD_START;
          end else if (sts.rem_zero && sts.q_le_np) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = tfds_pkg::RES_QSTEP;
            state_nxt    = tfds_pkg::ST_EMIT;
          end else begin
            cmd.d_inc = 1'b1;
            state_nxt = tfds_pkg::ST_FWD_START;
          end
        end
      end
      tfds_pkg::ST_BWD_START: begin
        if (sts.d_zero) begin
          cmd.res_load = 1'b1;
          state_nxt    = tfds_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = tfds_pkg::ST_BWD;
        end
      end
      tfds_pkg::ST_BWD: begin
        if (sts.div_done) begin
          if (sts.rem_zero && sts.d_le_np) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = tfds_pkg::RES_DSTEP;
            state_nxt    = tfds_pkg::ST_EMIT;
          end else begin
            cmd.d_dec = 1'b1;
            state_nxt = tfds_pkg::ST_BWD_START;
          end
        end
      end
      tfds_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tfds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tfds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/tile_factor_divisor_search_core.sv */
// Top level: tile factor search, controller and datapath joined by command/status.
`timescale 1ns / 1ps
// Takes one query per transfer (dynamic flag, loop bound, preferred size,
// required multiple) and returns one tile factor per query, in order. The
// block handles one query at a time: in_if.ready is high only while the
// controller is idle, though a finished result may still wait in the output
// register. Queries that settle on the flags and signed compares (preferred
// size not positive, dynamic bound, bound not positive, preferred size below
// the multiple) set their result in the classify state and show it from the
// output register after the emit state, once the output register is free.
// Otherwise every division runs on one shared restoring divider that yields
// one quotient bit per cycle: the bound, and then the preferred size, are
// divided by the multiple, followed by one division per trial divisor; there
// are from none up to about 2 * sqrt(bound / multiple) trial divisors.
module tile_factor_divisor_search_core (
  input  logic       clk,
  input  logic       rst_n,
  tfds_in_if.sink    in_if,
  tfds_out_if.source out_if
);

  tfds_pkg::cmd_t cmd;
  tfds_pkg::sts_t sts;

  // sequence the search: classify, divide by the step, walk divisors
  tfds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold operands, run the divider, form the result, drive the output transfer
  tfds_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

/* hw/rtl/tfds_checker.sv */
// Checker: port-level assertions for the tile factor core, with its bind.
`timescale 1ns / 1ps
module tfds_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tfds_pkg::VALUE_BITS-1:0] out_tile_factor
);

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transfer");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tile_factor))
    else $error("result changed while stalled");

  a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second query taken while one is in work");

  a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result shown without a finished query");

endmodule

bind tile_factor_divisor_search_core tfds_checker u_tfds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_tile_factor (out_if.tile_factor)
);
